@@ hdl/usvg_pkg.sv @@
// usvg_pkg: shared types, register codes and cordic constants for the uv sphere vertex generator
// no dependencies
package usvg_pkg;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RINGS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SECTORS = 2'd2;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam int CordicStages = 20;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i), 2^32 per full turn
  localparam logic signed [32:0] ATAN_TURNS [CordicStages] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
    33'sd21354465, 33'sd10680862, 33'sd5340245, 33'sd2670163, 33'sd1335087,
    33'sd667544, 33'sd333772, 33'sd166886, 33'sd83443, 33'sd41722,
    33'sd20861, 33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304
  };

  typedef struct packed {
    logic [7:0]  ring;
    logic [7:0]  sect;
    logic [8:0]  den_pol;
    logic [8:0]  den_az;
    logic [15:0] radius;
    logic [15:0] idx_top;
    logic [16:0] idx_bot;
  } job_t;

  function automatic logic signed [15:0] clamp_q14(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd16384) r = 16'sd16384;
    else if (v < -48'sd16384) r = -16'sd16384;
    else r = 16'(v);
    return r;
  endfunction

endpackage

@@ hdl/usvg_front.sv @@
// usvg_front: configuration registers and item classification (counts, divisors, indices)
// depends on usvg_pkg
module usvg_front import usvg_pkg::*; #(
  parameter int MAX_DIVISIONS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [7:0]         ring_index_i,
  input  logic [7:0]         sector_index_i,
  output job_t               job_o
);

  localparam int MaxC = (MAX_DIVISIONS > 511) ? 511 : MAX_DIVISIONS;

  logic [15:0] radius_q;
  logic [8:0]  rings_q, sects_q;
  logic [8:0]  rings_eff, sects_eff;
  logic [18:0] top_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      rings_q  <= 9'd24;
      sects_q  <= 9'd48;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RADIUS:  radius_q <= cfg_data_i;
        CFG_RINGS:   rings_q  <= cfg_data_i[8:0];
        CFG_SECTORS: sects_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // saturate counts to two .. max
  always_comb begin
    rings_eff = rings_q;
    if (rings_q < 9'd2) rings_eff = 9'd2;
    else if (rings_q > 9'(MaxC)) rings_eff = 9'(MaxC);
    sects_eff = sects_q;
    if (sects_q < 9'd2) sects_eff = 9'd2;
    else if (sects_q > 9'(MaxC)) sects_eff = 9'(MaxC);
  end

  assign top_full = 19'(ring_index_i) * 19'(sects_eff) + 19'(sector_index_i);

  always_comb begin
    job_o.ring    = ring_index_i;
    job_o.sect    = sector_index_i;
    job_o.den_pol = rings_eff - 9'd1;
    job_o.den_az  = sects_eff - 9'd1;
    job_o.radius  = radius_q;
    job_o.idx_top = top_full[15:0];
    job_o.idx_bot = 17'(top_full + 19'(sects_eff));
  end

endmodule

@@ hdl/usvg_queue.sv @@
// usvg_queue: short item queue between front and back
// depends on usvg_pkg
module usvg_queue import usvg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hdl/usvg_div.sv @@
// usvg_div: pipelined restoring divider, one quotient bit per stage
// depends on usvg_pkg
module usvg_div import usvg_pkg::*; #(
  parameter int NW = 20
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [9:0]    dvs_i,
  output logic [NW-1:0] quo_o
);

  logic [9:0]    rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [9:0]    dvs_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [9:0]    rem_p, dvs_p;
    logic [NW-1:0] num_p, quo_p, quo_n;
    logic [10:0]   trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = num_i;
      assign quo_p = '0;
      assign dvs_p = dvs_i;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign num_p = num_q[k-1];
      assign quo_p = quo_q[k-1];
      assign dvs_p = dvs_q[k-1];
    end
    assign trial = {rem_p, num_p[NW-1-k]};
    assign ge    = (trial >= {1'b0, dvs_p});
    always_comb begin
      quo_n = quo_p;
      quo_n[NW-1-k] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 10'(trial - {1'b0, dvs_p}) : trial[9:0];
        num_q[k] <= num_p;
        quo_q[k] <= quo_n;
        dvs_q[k] <= dvs_p;
      end
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule

@@ hdl/usvg_cordic.sv @@
// usvg_cordic: pipelined rotation cordic giving q1.14 sine and cosine of a phase
// depends on usvg_pkg
module usvg_cordic import usvg_pkg::*; #(
  parameter int TB = 10
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [TB-1:0]       phase_i,
  output logic signed [15:0]  sin_o,
  output logic signed [15:0]  cos_o
);

  logic signed [33:0] x_q [CordicStages];
  logic signed [33:0] y_q [CordicStages];
  logic signed [32:0] z_q [CordicStages];
  logic [1:0]         quad_q [CordicStages];
  logic signed [32:0] z_init;

  // phase below the quadrant as a 30 bit turn fraction
  assign z_init = signed'(33'({phase_i[TB-3:0], (32-TB)'(0)}));

  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    logic signed [33:0] x_p, y_p;
    logic signed [32:0] z_p;
    logic [1:0]         quad_p;
    if (i == 0) begin : g_first
      assign x_p = CORDIC_GAIN;
      assign y_p = '0;
      assign z_p = z_init;
      assign quad_p = phase_i[TB-1:TB-2];
    end else begin : g_next
      assign x_p = x_q[i-1];
      assign y_p = y_q[i-1];
      assign z_p = z_q[i-1];
      assign quad_p = quad_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_p[32]) begin
          x_q[i] <= x_p - (y_p >>> i);
          y_q[i] <= y_p + (x_p >>> i);
          z_q[i] <= z_p - ATAN_TURNS[i];
        end else begin
          x_q[i] <= x_p + (y_p >>> i);
          y_q[i] <= y_p - (x_p >>> i);
          z_q[i] <= z_p + ATAN_TURNS[i];
        end
        quad_q[i] <= quad_p;
      end
    end
  end

  logic signed [33:0] xr, yr;
  logic signed [15:0] c, s;

  assign xr = (x_q[CordicStages-1] + 34'sd32768) >>> 16;
  assign yr = (y_q[CordicStages-1] + 34'sd32768) >>> 16;
  assign c  = clamp_q14(48'(xr));
  assign s  = clamp_q14(48'(yr));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (quad_q[CordicStages-1])
        2'd0: begin cos_o <= c;  sin_o <= s;  end
        2'd1: begin cos_o <= -s; sin_o <= c;  end
        2'd2: begin cos_o <= -c; sin_o <= -s; end
        default: begin cos_o <= s; sin_o <= -c; end
      endcase
    end
  end

endmodule

@@ hdl/usvg_back.sv @@
// usvg_back: phase division, trig and vertex arithmetic pipeline with output register
// depends on usvg_pkg, usvg_div, usvg_cordic
module usvg_back import usvg_pkg::*; #(
  parameter int TB = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  job_t                q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [16:0]  pos_x_o,
  output logic signed [16:0]  pos_y_o,
  output logic signed [16:0]  pos_z_o,
  output logic signed [15:0]  normal_x_o,
  output logic signed [15:0]  normal_y_o,
  output logic signed [15:0]  normal_z_o,
  output logic [16:0]         tex_u_o,
  output logic [16:0]         tex_v_o,
  output logic [15:0]         index_top_o,
  output logic [16:0]         index_bottom_o
);

  localparam int NW  = TB + 10;
  localparam int Lat = NW + CordicStages + 1;

  typedef struct packed {
    logic [15:0] radius;
    logic [15:0] idx_top;
    logic [16:0] idx_bot;
  } side_t;

  logic en;
  assign en      = !out_valid_o || out_ready_i;
  assign q_pop_o = en && q_valid_i;

  logic [NW-1:0] num_pol, num_az, quo_pol, quo_az;
  assign num_pol = (NW'(q_data_i.ring) << TB) + NW'(q_data_i.den_pol);
  assign num_az  = (NW'(q_data_i.sect) << (TB + 1)) + NW'(q_data_i.den_az);

  usvg_div #(.NW(NW)) u_div_pol (
    .clk_i(clk_i), .en_i(en), .num_i(num_pol), .dvs_i({q_data_i.den_pol, 1'b0}),
    .quo_o(quo_pol)
  );
  usvg_div #(.NW(NW)) u_div_az (
    .clk_i(clk_i), .en_i(en), .num_i(num_az), .dvs_i({q_data_i.den_az, 1'b0}),
    .quo_o(quo_az)
  );

  logic signed [15:0] sp, cp, sa, ca;

  usvg_cordic #(.TB(TB)) u_trig_pol (
    .clk_i(clk_i), .en_i(en), .phase_i(quo_pol[TB-1:0]), .sin_o(sp), .cos_o(cp)
  );
  usvg_cordic #(.TB(TB)) u_trig_az (
    .clk_i(clk_i), .en_i(en), .phase_i(quo_az[TB-1:0]), .sin_o(sa), .cos_o(ca)
  );

  // side data and valid travel alongside the divider and cordic stages
  side_t side_q [Lat];
  logic  vld_q  [Lat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{radius: q_data_i.radius, idx_top: q_data_i.idx_top,
                     idx_bot: q_data_i.idx_bot};
      for (int i = 1; i < Lat; i++) side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= q_valid_i;
      for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // first products
  logic signed [16:0] rad_s, ncp;
  assign rad_s = signed'({1'b0, side_q[Lat-1].radius});
  assign ncp   = -(17'(cp));

  logic               m1_v_q, m2_v_q;
  side_t              m1_side_q, m2_side_q;
  logic signed [31:0] m1_xs_q, m1_zs_q;
  logic signed [33:0] m1_py_q;
  logic signed [15:0] m1_ny_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_side_q <= side_q[Lat-1];
      m1_xs_q   <= ca * sp;
      m1_zs_q   <= sa * sp;
      m1_py_q   <= ncp * rad_s;
      m1_ny_q   <= 16'(ncp);
    end
  end

  // radius products and normal rounding
  logic signed [16:0] m1_rad;
  assign m1_rad = signed'({1'b0, m1_side_q.radius});

  logic signed [48:0] m2_px_q, m2_pz_q;
  logic signed [16:0] m2_py_q;
  logic signed [15:0] m2_nx_q, m2_ny_q, m2_nz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_side_q <= m1_side_q;
      m2_px_q   <= m1_xs_q * m1_rad;
      m2_pz_q   <= m1_zs_q * m1_rad;
      m2_py_q   <= 17'((m1_py_q + 34'sd8192) >>> 14);
      m2_nx_q   <= clamp_q14(48'((m1_xs_q + 32'sd8192) >>> 14));
      m2_nz_q   <= clamp_q14(48'((m1_zs_q + 32'sd8192) >>> 14));
      m2_ny_q   <= m1_ny_q;
    end
  end

  // final rounding, zero radius and texture mapping
  logic               zero_rad;
  logic signed [15:0] nx, ny, nz;
  logic [17:0]        tu, tv;
  assign zero_rad = (m2_side_q.radius == '0);
  assign nx = zero_rad ? '0 : m2_nx_q;
  assign ny = zero_rad ? '0 : m2_ny_q;
  assign nz = zero_rad ? '0 : m2_nz_q;
  assign tu = 18'({nx[15], nx, 1'b0}) + 18'd32768;
  assign tv = 18'({ny[15], ny, 1'b0}) + 18'd32768;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_o        <= zero_rad ? '0 : 17'((m2_px_q + 49'sd134217728) >>> 28);
      pos_y_o        <= zero_rad ? '0 : m2_py_q;
      pos_z_o        <= zero_rad ? '0 : 17'((m2_pz_q + 49'sd134217728) >>> 28);
      normal_x_o     <= nx;
      normal_y_o     <= ny;
      normal_z_o     <= nz;
      tex_u_o        <= tu[16:0];
      tex_v_o        <= tv[16:0];
      index_top_o    <= m2_side_q.idx_top;
      index_bottom_o <= m2_side_q.idx_bot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q      <= 1'b0;
      m2_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      m1_v_q      <= vld_q[Lat-1];
      m2_v_q      <= m1_v_q;
      out_valid_o <= m2_v_q;
    end
  end

endmodule

@@ hdl/uv_sphere_vertex_generator_unit.sv @@
// uv sphere vertex generator: an accepted input item passes through the queue,
// TRIG_TABLE_BITS + 10 divider stages, the cordic stages and their output register, two
// product stages and the output register; one item per cycle sustained, and a full output
// stalls the whole back pipeline
// reset: radius 1.0, 24 rings, 48 sectors, queue empty, no result pending
// depends on usvg_pkg, usvg_front, usvg_queue, usvg_back
module uv_sphere_vertex_generator_unit import usvg_pkg::*; #(
  parameter int MAX_DIVISIONS   = 256,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  // input item
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          ring_index_i,
  input  logic [7:0]          sector_index_i,
  // result item
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [16:0]  pos_x_o,
  output logic signed [16:0]  pos_y_o,
  output logic signed [16:0]  pos_z_o,
  output logic signed [15:0]  normal_x_o,
  output logic signed [15:0]  normal_y_o,
  output logic signed [15:0]  normal_z_o,
  output logic [16:0]         tex_u_o,
  output logic [16:0]         tex_v_o,
  output logic [15:0]         index_top_o,
  output logic [16:0]         index_bottom_o
);

  job_t front_job, queue_job;
  logic q_full, q_valid, q_pop, push;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // item enters the queue whenever there is room
  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  // front: register file, count saturation, divisors and row base indices
  usvg_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .ring_index_i(ring_index_i), .sector_index_i(sector_index_i),
    .job_o(front_job)
  );

  // short queue decouples input acceptance from back stalls
  usvg_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(push), .data_i(front_job), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(queue_job)
  );

  // back: phase division, sine and cosine, scaling, output register
  usvg_back #(.TB(TRIG_TABLE_BITS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .q_valid_i(q_valid), .q_data_i(queue_job), .q_pop_o(q_pop),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .pos_z_o(pos_z_o),
    .normal_x_o(normal_x_o), .normal_y_o(normal_y_o), .normal_z_o(normal_z_o),
    .tex_u_o(tex_u_o), .tex_v_o(tex_v_o),
    .index_top_o(index_top_o), .index_bottom_o(index_bottom_o)
  );

endmodule
